>>> src/layer_priority_compositor_top_macros.svh
// ----------------------------------------------------------------------------
// layer_priority_compositor_top_macros.svh
// Assertion macros for the layer priority compositor; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef LAYER_PRIORITY_COMPOSITOR_TOP_MACROS_SVH
`define LAYER_PRIORITY_COMPOSITOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on clk, quiet during reset
`define LPC_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");
// next-cycle implication
`define LPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define LPC_ASSERT(lbl, ante, cons)
`define LPC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> src/lpc_pkg.sv
// ----------------------------------------------------------------------------
// lpc_pkg
// Types and constants shared by the layer priority compositor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpc_pkg;

  localparam int PALETTE_ENTRIES_DEF = 64;
  localparam int ADDR_W  = 6;
  localparam int COLOR_W = 9;
  localparam int CFG_W   = 4;

  // opcodes
  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_RESOLVE = 1'b1;

  // register indexes
  localparam logic [1:0] CFG_SH_ENABLE  = 2'd0;
  localparam logic [1:0] CFG_FULL_COLOR = 2'd1;
  localparam logic [1:0] CFG_BG_PALETTE = 2'd2;
  localparam logic [1:0] CFG_BG_INDEX   = 2'd3;

  // shadow/highlight operator codes, highlight step, component limit and colour masks
  localparam logic [1:0] SH_LINE    = 2'd3;
  localparam logic [3:0] IDX_HILITE = 4'd14;
  localparam logic [3:0] IDX_SHADOW = 4'd15;
  localparam logic [3:0] HILITE_STEP = 4'd3;
  localparam logic [3:0] COMP_MAX    = 4'd7;
  localparam logic [2:0] MASK_FULL   = 3'h7;
  localparam logic [2:0] MASK_REDUCED = 3'h1;

  typedef struct packed {
    logic       opcode;
    logic [5:0] entry_index;
    logic [11:0] entry_word;
    logic [3:0] plane_a_color;
    logic [1:0] plane_a_palette;
    logic       plane_a_high;
    logic [3:0] plane_b_color;
    logic [1:0] plane_b_palette;
    logic       plane_b_high;
    logic [3:0] sprite_color;
    logic [1:0] sprite_palette;
    logic       sprite_high;
  } in_item_t;

  typedef struct packed {
    logic [2:0] red;
    logic [2:0] green;
    logic [2:0] blue;
  } out_item_t;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] data;
  } pal_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } pal_rd_t;

endpackage

>>> src/lpc_palette.sv
// ----------------------------------------------------------------------------
// lpc_palette
// Colour palette store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpc_palette import lpc_pkg::*; #(
  parameter int ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pal_wr_t            wr,
  input  pal_rd_t            rd,
  output logic [COLOR_W-1:0] rd_data
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [COLOR_W-1:0] mem [ENTRIES];
  logic [ENTRIES-1:0] vld_r;
  logic [COLOR_W-1:0] rdata_r;
  logic               rvld_r;
  logic               wr_in_range;
  logic               rd_in_range;

  assign wr_in_range = (int'(wr.addr) < ENTRIES);
  assign rd_in_range = (int'(rd.addr) < ENTRIES);

  always_ff @(posedge clk) begin
    if (wr.en && wr_in_range) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
    if (rd.en) begin
      rdata_r <= mem[rd.addr[AW-1:0]];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (wr.en && wr_in_range) begin
        vld_r[wr.addr[AW-1:0]] <= 1'b1;
      end
      if (rd.en) begin
        rvld_r <= rd_in_range && vld_r[rd.addr[AW-1:0]];
      end
    end
  end

  assign rd_data = rvld_r ? rdata_r : '0;

endmodule

>>> src/layer_priority_compositor_top.sv
// Path: a resolve transfer passes the lookup stage, then the output register.
// Throughput: one item per cycle while not stalled; the single palette read
// port serves each pixel. Write items land in the palette and give no pixel.
// Reset (synchronous, rst_n low) restores register defaults and marks all
// palette entries as zero by clearing their valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// layer_priority_compositor_top
// Per-pixel layer priority resolve with shadow/highlight and palette lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "layer_priority_compositor_top_macros.svh"

module layer_priority_compositor_top import lpc_pkg::*; #(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  // configuration registers
  logic       sh_en_r;
  logic       full_r;
  logic [1:0] bg_pal_r;
  logic [3:0] bg_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_en_r  <= 1'b0;
      full_r   <= 1'b1;
      bg_pal_r <= '0;
      bg_idx_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SH_ENABLE:  sh_en_r  <= cfg_wdata[0];
        CFG_FULL_COLOR: full_r   <= cfg_wdata[0];
        CFG_BG_PALETTE: bg_pal_r <= cfg_wdata[1:0];
        CFG_BG_INDEX:   bg_idx_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // flow control: the output register takes a pixel when empty or draining;
  // the lookup stage advances when empty or when the output can take its pixel
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_take, s1_adv, in_fire;

  assign out_take = !out_valid_r || !out_stall;
  assign s1_adv   = !s1_valid_r || out_take;
  assign in_stall = !s1_adv;
  assign in_fire  = in_valid && !in_stall;

  // layer selection on the incoming item
  logic a_op, b_op, s_op, sh_op;
  logic [1:0] sel_line;
  logic [3:0] sel_idx;

  assign a_op  = (in_data.plane_a_color != '0);
  assign b_op  = (in_data.plane_b_color != '0);
  assign s_op  = (in_data.sprite_color  != '0);
  assign sh_op = sh_en_r && s_op && (in_data.sprite_palette == SH_LINE) &&
                 ((in_data.sprite_color == IDX_HILITE) ||
                  (in_data.sprite_color == IDX_SHADOW));

  always_comb begin
    sel_line = bg_pal_r;
    sel_idx  = bg_idx_r;
    if (sh_op) begin
      // operator sprite is not drawn: take the colour beneath it
      if (a_op && in_data.plane_a_high) begin
        sel_line = in_data.plane_a_palette;
        sel_idx  = in_data.plane_a_color;
      end else if (b_op && in_data.plane_b_high) begin
        sel_line = in_data.plane_b_palette;
        sel_idx  = in_data.plane_b_color;
      end else if (a_op) begin
        sel_line = in_data.plane_a_palette;
        sel_idx  = in_data.plane_a_color;
      end else if (b_op) begin
        sel_line = in_data.plane_b_palette;
        sel_idx  = in_data.plane_b_color;
      end
    end else begin
      if (s_op && in_data.sprite_high) begin
        sel_line = in_data.sprite_palette;
        sel_idx  = in_data.sprite_color;
      end else if (a_op && in_data.plane_a_high) begin
        sel_line = in_data.plane_a_palette;
        sel_idx  = in_data.plane_a_color;
      end else if (b_op && in_data.plane_b_high) begin
        sel_line = in_data.plane_b_palette;
        sel_idx  = in_data.plane_b_color;
      end else if (s_op) begin
        sel_line = in_data.sprite_palette;
        sel_idx  = in_data.sprite_color;
      end else if (a_op) begin
        sel_line = in_data.plane_a_palette;
        sel_idx  = in_data.plane_a_color;
      end else if (b_op) begin
        sel_line = in_data.plane_b_palette;
        sel_idx  = in_data.plane_b_color;
      end
    end
  end

  // palette access: writes land at the transfer, the resolve read is registered
  pal_wr_t            pal_wr;
  pal_rd_t            pal_rd;
  logic [COLOR_W-1:0] pal_data;

  assign pal_wr.en   = in_fire && (in_data.opcode == OP_WRITE);
  assign pal_wr.addr = in_data.entry_index;
  assign pal_wr.data = {in_data.entry_word[11:9], in_data.entry_word[7:5],
                        in_data.entry_word[3:1]};
  assign pal_rd.en   = in_fire && (in_data.opcode == OP_RESOLVE);
  assign pal_rd.addr = {sel_line, sel_idx};

  lpc_palette #(
    .ENTRIES (PALETTE_ENTRIES)
  ) u_palette (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (pal_wr),
    .rd      (pal_rd),
    .rd_data (pal_data)
  );

  // lookup stage: hold operator and mode alongside the read
  logic s1_hilite_r, s1_shadow_r, s1_full_r;

  assign s1_valid_nxt = s1_adv ? pal_rd.en : s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pal_rd.en) begin
      s1_hilite_r <= sh_op && (in_data.sprite_color == IDX_HILITE);
      s1_shadow_r <= sh_op && (in_data.sprite_color == IDX_SHADOW);
      s1_full_r   <= full_r;
    end
  end

  // colour stage: mask per mode, then apply the operator
  logic [2:0] mask;
  logic [2:0] comp  [3];
  logic [2:0] shade [3];
  logic [3:0] sum   [3];
  out_item_t  pix;

  assign mask    = s1_full_r ? MASK_FULL : MASK_REDUCED;
  assign comp[0] = pal_data[2:0] & mask;
  assign comp[1] = pal_data[5:3] & mask;
  assign comp[2] = pal_data[8:6] & mask;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = {1'b0, comp[i]} + HILITE_STEP;
      if (s1_hilite_r) begin
        shade[i] = (sum[i] > COMP_MAX) ? COMP_MAX[2:0] : sum[i][2:0];
      end else if (s1_shadow_r) begin
        shade[i] = comp[i] >> 1;
      end else begin
        shade[i] = comp[i];
      end
    end
  end

  assign pix.red   = shade[0];
  assign pix.green = shade[1];
  assign pix.blue  = shade[2];

  // output register
  out_item_t out_data_r;

  assign out_valid_nxt = out_take ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && s1_valid_r) begin
      out_data_r <= pix;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a write transfer never occupies the lookup stage
  `LPC_ASSERT_NEXT(a_wr_no_slot, in_fire && (in_data.opcode == OP_WRITE), !s1_valid_r)
  // a resolve transfer always occupies it
  `LPC_ASSERT_NEXT(a_rs_slot, in_fire && (in_data.opcode == OP_RESOLVE), s1_valid_r)
  // both stages full and the output stalled: refuse input
  `LPC_ASSERT(a_full_stall, s1_valid_r && out_valid_r && out_stall, in_stall)
  // a looked-up pixel moves to the output when there is room
  `LPC_ASSERT_NEXT(a_out_load, s1_valid_r && !(out_valid_r && out_stall), out_valid_r)

endmodule
